### rtl/life_generation_stencil_macros.svh
// assertion macros shared by the stencil modules
`ifndef LIFE_GENERATION_STENCIL_MACROS_SVH
`define LIFE_GENERATION_STENCIL_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define LGS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define LGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lgs_pkg.sv
// shared types, constants and functions of the life stencil
package lgs_pkg;

    // configuration register widths and reset values
    localparam int GRID_W          = 11;
    localparam int CFG_INDEX_W     = 2;
    localparam int GRID_WIDTH_RST  = 320;
    localparam int GRID_HEIGHT_RST = 240;

    // default storage bounds
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    // one classified cell handed from front to back
    typedef struct packed {
        logic       c_first;   // first column of a row
        logic       c_last;    // last column of a row
        logic       r_ge1;     // middle row holds real cells
        logic       r_ge2;     // upper row holds real cells
        logic       frame;     // padding row, last result of the generation
        logic       bot;       // lower row cell, dead in the padding row
        logic [1:0] line;      // line buffer entry: bit1 upper, bit0 middle
    } lgs_item_t;

    // one result item
    typedef struct packed {
        logic next_alive;
        logic row_last;
        logic frame_last;
    } lgs_result_t;

    // up to two results pushed by the back in one cycle, in order
    typedef struct packed {
        logic        first_valid;
        logic        second_valid;
        lgs_result_t first;
        lgs_result_t second;
    } lgs_push_t;

    // clamp a written size to 1..maxv
    function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] v,
                                                     input int maxv);
        if (v == '0) begin
            return GRID_W'(1);
        end
        else if (int'(v) > maxv) begin
            return GRID_W'(maxv);
        end
        else begin
            return v;
        end
    endfunction

    // b3/s23 rule on a 3x3 neighborhood given as columns, bit0 top, bit2 bottom
    function automatic logic life_rule(input logic [2:0] left,
                                       input logic [2:0] centre,
                                       input logic [2:0] right);
        logic [3:0] n;
        n = 4'(left[0]) + 4'(left[1]) + 4'(left[2])
          + 4'(right[0]) + 4'(right[1]) + 4'(right[2])
          + 4'(centre[0]) + 4'(centre[2]);
        if (centre[1]) begin
            return (n == 4'd2) || (n == 4'd3);
        end
        else begin
            return n == 4'd3;
        end
    endfunction

endpackage

### rtl/lgs_front.sv
// front: config registers, raster position, line buffers and item stage
`include "life_generation_stencil_macros.svh"

module lgs_front
    import lgs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GRID_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   alive,
    output logic                   item_valid,
    output lgs_item_t              item,
    input  logic                   take
);

    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COL_CMP_W = (ADDR_W + 1 > GRID_W) ? ADDR_W + 1 : GRID_W;
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_CMP_W = (ROW_W > GRID_W) ? ROW_W : GRID_W;

    logic [GRID_W-1:0] grid_width_reg, grid_width_next;
    logic [GRID_W-1:0] grid_height_reg, grid_height_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              item_valid_reg, item_valid_next;
    lgs_item_t         item_reg;
    logic [1:0]        line_reg;
    logic [ADDR_W-1:0] addr_reg;

    // line buffers, one entry per column: bit1 upper row, bit0 middle row
    logic [1:0]        line_mem [MAX_WIDTH];

    logic              accept;
    logic              cfg_write;
    logic              col_last;
    logic              row_pad;
    logic              row_wrap;
    logic              fwd;
    lgs_item_t         item_new;
    lgs_item_t         item_out;

    assign cfg_ready = 1'b1;
    assign in_ready  = !item_valid_reg || take;
    assign accept    = in_valid && in_ready;
    assign cfg_write = cfg_valid
                    && ((cfg_index == REG_GRID_WIDTH) || (cfg_index == REG_GRID_HEIGHT));

    // position decode
    assign col_last = (COL_CMP_W'(col_reg) + 1'b1) == COL_CMP_W'(grid_width_reg);
    assign row_pad  = ROW_CMP_W'(row_reg) == ROW_CMP_W'(grid_height_reg);
    assign row_wrap = ROW_CMP_W'(row_reg) >= ROW_CMP_W'(grid_height_reg);

    // config register update
    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_valid && (cfg_index == REG_GRID_WIDTH)) begin
            grid_width_next = clamp_grid(cfg_data, MAX_WIDTH);
        end
        if (cfg_valid && (cfg_index == REG_GRID_HEIGHT)) begin
            grid_height_next = clamp_grid(cfg_data, MAX_HEIGHT);
        end
    end

    // raster position, restarted by a config write
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_write) begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + 1'b1;
            end
            else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // classify the incoming cell
    always_comb
    begin
        item_new         = '0;
        item_new.c_first = col_reg == '0;
        item_new.c_last  = col_last;
        item_new.r_ge1   = row_reg != '0;
        item_new.r_ge2   = row_reg >= ROW_W'(2);
        item_new.frame   = row_pad;
        item_new.bot     = alive && !row_pad;
        item_new.line    = '0;
    end

    // item stage occupancy
    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept) begin
            item_valid_next = 1'b1;
        end
        else if (take) begin
            item_valid_next = 1'b0;
        end
    end

    // a column written back this cycle is read again only at width one
    assign fwd = take && (addr_reg == col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grid_width_reg  <= clamp_grid(GRID_W'(GRID_WIDTH_RST), MAX_WIDTH);
            grid_height_reg <= clamp_grid(GRID_W'(GRID_HEIGHT_RST), MAX_HEIGHT);
            col_reg         <= '0;
            row_reg         <= '0;
            item_valid_reg  <= 1'b0;
        end
        else begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            item_valid_reg  <= item_valid_next;
        end
    end

    // item payload with registered line buffer read
    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_reg <= item_new;
            addr_reg <= col_reg;
            if (fwd) begin
                line_reg <= {line_reg[0], item_reg.bot};
            end
            else begin
                line_reg <= line_mem[col_reg];
            end
        end
    end

    // line buffer write back: middle moves up, new cell becomes middle
    always_ff @(posedge clk)
    begin
        if (take) begin
            line_mem[addr_reg] <= {line_reg[0], item_reg.bot};
        end
    end

    // staged item with its line buffer entry
    always_comb
    begin
        item_out      = item_reg;
        item_out.line = line_reg;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_out;

    `LGS_ASSERT_NEXT(a_item_holds, clk, rst_n, item_valid_reg && !take, item_valid_reg,
        "item stage dropped an item that was not taken")
    `LGS_ASSERT_SAME(a_take_needs_item, clk, rst_n, take, item_valid_reg,
        "back took an item from an empty stage")

endmodule

### rtl/lgs_back.sv
// back: column window and next-state rule, emits up to two results
`include "life_generation_stencil_macros.svh"

module lgs_back
    import lgs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  lgs_item_t item,
    output logic      take,
    input  logic      room,
    output lgs_push_t push
);

    logic [5:0] window_reg, window_next;
    logic [5:0] prev;
    logic [2:0] col;
    logic       top;
    logic       mid;

    assign take = item_valid && room;

    // current column and previous two columns
    always_comb
    begin
        top  = item.r_ge2 && item.line[1];
        mid  = item.r_ge1 && item.line[0];
        col  = {item.bot, mid, top};
        prev = item.c_first ? 6'd0 : window_reg;
    end

    // results for the cell one column left, and for the row end
    always_comb
    begin
        push                   = '0;
        push.first_valid       = take && item.r_ge1 && !item.c_first;
        push.first.next_alive  = life_rule(prev[5:3], prev[2:0], col);
        push.first.row_last    = 1'b0;
        push.first.frame_last  = 1'b0;
        push.second_valid      = take && item.r_ge1 && item.c_last;
        push.second.next_alive = life_rule(prev[2:0], col, 3'd0);
        push.second.row_last   = 1'b1;
        push.second.frame_last = item.frame;
    end

    // window shift
    always_comb
    begin
        window_next = window_reg;
        if (take) begin
            window_next = {prev[2:0], col};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            window_reg <= '0;
        end
        else begin
            window_reg <= window_next;
        end
    end

    `LGS_ASSERT_SAME(a_row_end_result, clk, rst_n, take && item.r_ge1 && item.c_last,
        push.second_valid && push.second.row_last,
        "row end produced no row_last result")
    `LGS_ASSERT_SAME(a_no_first_result, clk, rst_n, !item.r_ge1,
        !push.first_valid && !push.second_valid,
        "first input row produced a result")

endmodule

### rtl/lgs_queue.sv
// result queue: up to two pushes and one pop per cycle
`include "life_generation_stencil_macros.svh"

module lgs_queue
    import lgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lgs_push_t   push,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output lgs_result_t out_data
);

    lgs_result_t       q_mem [QDEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [1:0]        push_n;
    logic              pop;
    logic [QPTR_W-1:0] second_addr;

    assign push_n      = {1'b0, push.first_valid} + {1'b0, push.second_valid};
    assign pop         = out_valid && out_ready;
    assign room        = count_reg <= QCNT_W'(QDEPTH - 2);
    assign out_valid   = count_reg != '0;
    assign out_data    = q_mem[head_reg];
    assign second_addr = push.first_valid ? tail_reg + 1'b1 : tail_reg;

    // pointer and fill update
    always_comb
    begin
        tail_next  = tail_reg + QPTR_W'(push_n);
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        count_next = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage, results kept in order
    always_ff @(posedge clk)
    begin
        if (push.first_valid) begin
            q_mem[tail_reg] <= push.first;
        end
        if (push.second_valid) begin
            q_mem[second_addr] <= push.second;
        end
    end

    `LGS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= QCNT_W'(QDEPTH),
        "result queue overflow")
    `LGS_ASSERT_SAME(a_push_with_room, clk, rst_n, push.first_valid || push.second_valid,
        room, "result pushed without room for two")

endmodule

### rtl/life_generation_stencil.sv
// top level of the streaming game of life next-generation stencil
//
// Cells of one generation enter in raster order, one per cycle, and the next
// generation leaves in raster order by rule B3/S23; after grid_height rows one
// padding row of grid_width items flushes the last row. Sustained rate is one
// input item per cycle while the result queue has room; an item's results
// are registered in the item stage and the result queue before they reach the
// output. Results leave through a four-entry queue, and the input stalls only
// when that queue holds more than two results, so a consumer that takes one
// result per cycle never stalls the input (a row end adds a second result,
// balanced by the first column, which adds none). Two line buffers of
// MAX_WIDTH one-bit entries, read and written once per cycle, hold the two
// previous rows; they need no clearing after reset. A config write restarts
// the stream at the first cell of a new generation; cfg_ready is always high,
// so the caller writes only while the block is idle.

module life_generation_stencil
    import lgs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GRID_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   alive,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   next_alive,
    output logic                   row_last,
    output logic                   frame_last
);

    logic        item_valid;
    lgs_item_t   item;
    logic        take;
    logic        room;
    lgs_push_t   push;
    lgs_result_t out_data;

    // accept, classify and buffer rows
    lgs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .alive      (alive),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    // window and rule
    lgs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .room       (room),
        .push       (push)
    );

    // result queue toward the consumer
    lgs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign next_alive = out_data.next_alive;
    assign row_last   = out_data.row_last;
    assign frame_last = out_data.frame_last;

endmodule
